// File: sv/tkm_pkg.sv
// ----------------------------------------------------------------------------
// tkm_pkg: shared types for the top-k smallest sorted list unit
// Payload structs for both channels, the neighbour link between list cells
// and the configuration register map.
// ----------------------------------------------------------------------------
package tkm_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned ID_W  = 31;
  localparam int unsigned K_W   = 5;

  localparam logic [K_W-1:0] K_RESET = 5'd16;

  // register word index (paddr[2])
  localparam logic REG_K_IN_USE = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0] item_key;
    logic [ID_W-1:0]  item_id;
  } tkm_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] kth_key;
    logic             list_full;
  } tkm_out_t;

  // what one cell hands to the next one down the list
  typedef struct packed {
    logic             le;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } tkm_link_t;

endpackage

// File: sv/tkm_cfg.sv
// ----------------------------------------------------------------------------
// tkm_cfg: configuration register file
// APB-style slave holding k_in_use; pready is tied high.
// ----------------------------------------------------------------------------
module tkm_cfg
  import tkm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output logic [K_W-1:0] k_in_use
);

  logic [K_W-1:0] k_in_use_r;
  logic [K_W-1:0] k_in_use_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_K_IN_USE);

  always_comb begin
    k_in_use_nxt = k_in_use_r;
    if (wr_en) begin
      k_in_use_nxt = pwdata[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_in_use_r <= K_RESET;
    end else begin
      k_in_use_r <= k_in_use_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_K_IN_USE) begin
      prdata = {{(32-K_W){1'b0}}, k_in_use_r};
    end
  end

  assign k_in_use = k_in_use_r;

endmodule

// File: sv/tkm_cell.sv
// ----------------------------------------------------------------------------
// tkm_cell: one slot of the sorted list
// Compares its entry with the offered key, then holds, takes the new pair
// or takes its upper neighbour's pair.
// ----------------------------------------------------------------------------
module tkm_cell
  import tkm_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic             active,
  input  logic [KEY_W-1:0] in_key,
  input  logic [ID_W-1:0]  in_id,
  input  tkm_link_t        prev,
  output tkm_link_t        link,
  output logic [KEY_W-1:0] key_nxt
);

  logic [KEY_W-1:0] key_r;
  logic [ID_W-1:0]  id_r;
  logic [ID_W-1:0]  id_nxt;
  logic             le;

  assign le = active && (key_r <= in_key);

  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    if (load && !le) begin
      if (prev.le) begin
        key_nxt = in_key;
        id_nxt  = in_id;
      end else begin
        key_nxt = prev.key;
        id_nxt  = prev.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

  assign link.le  = le;
  assign link.key = key_r;
  assign link.id  = id_r;

endmodule

// File: sv/top_k_min_sorted_list_unit.sv
// ----------------------------------------------------------------------------
// top_k_min_sorted_list_unit: keeps the k smallest (key, id) pairs in order
// A chain of list cells compares every entry with the offered key at once
// and shifts by one place behind the insertion point.
//
//   channel  direction  handshake              payload
//   in       slave      in_valid / in_stall    tkm_in_t  (item_key, item_id)
//   out      master     out_valid / out_stall  tkm_out_t (kth_key, list_full)
//   cfg      slave      psel/penable/pready    k_in_use at word 0
//
// One item per cycle unless stalled; the result is registered and appears the
// cycle after the transfer. The compare-and-shift across all cells sets that
// figure. Reset clears the held count and sets k_in_use to 16; cell contents
// hold. in_stall rises only while a result waits and out_stall is high.
// ----------------------------------------------------------------------------
module top_k_min_sorted_list_unit
  import tkm_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 16
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tkm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tkm_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [K_W-1:0]   k_in_use;
  logic [CW-1:0]    eff_k;
  logic [CW-1:0]    k_m1;
  logic [IW-1:0]    k_idx;
  logic [CW-1:0]    held_r;
  logic [CW-1:0]    held_nxt;
  logic [CW-1:0]    held_cut;
  logic             accept;
  logic             out_valid_r;
  logic             out_valid_nxt;
  tkm_out_t         out_data_r;
  tkm_out_t         out_data_nxt;
  tkm_link_t        links [MAX_DEPTH+1];
  logic [KEY_W-1:0] keys_nxt [MAX_DEPTH];

  tkm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .k_in_use (k_in_use)
  );

  // clamp k to 1..MAX_DEPTH
  always_comb begin
    if (k_in_use == '0) begin
      eff_k = CW'(1);
    end else if (int'(k_in_use) > int'(MAX_DEPTH)) begin
      eff_k = CW'(MAX_DEPTH);
    end else begin
      eff_k = CW'(k_in_use);
    end
  end

  assign k_m1  = eff_k - CW'(1);
  assign k_idx = k_m1[IW-1:0];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign held_cut = (held_r > eff_k) ? eff_k : held_r;
  assign held_nxt = (held_cut < eff_k) ? held_cut + CW'(1) : held_cut;

  assign links[0].le  = 1'b1;
  assign links[0].key = '0;
  assign links[0].id  = '0;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    tkm_cell u_cell (
      .clk     (clk),
      .load    (accept),
      .active  (CW'(i) < held_cut),
      .in_key  (in_data.item_key),
      .in_id   (in_data.item_id),
      .prev    (links[i]),
      .link    (links[i+1]),
      .key_nxt (keys_nxt[i])
    );
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.list_full = (held_nxt == eff_k);
      out_data_nxt.kth_key   = (held_nxt == eff_k) ? keys_nxt[k_idx] : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        held_r <= held_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(held_r) <= int'(MAX_DEPTH))
    else $error("held count beyond list depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && (held_r != '0))
    else $error("transfer without result or held entry");

  a_full_matches: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data_r.list_full == (held_r == eff_k))
    else $error("full flag disagrees with held count");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.list_full |-> out_data_r.kth_key == '1)
    else $error("sentinel missing while list not full");

endmodule

// File: bench/tb_top_k_min_sorted_list_unit.sv
// ----------------------------------------------------------------------------
// tb_top_k_min_sorted_list_unit: self-checking bench for the top-k list unit
// Offers (key, id) pairs over the valid/stall input channel and writes
// k_in_use over the register port between phases. A tracker class keeps
// its own sorted list to predict the k-th key and full flag for every
// transfer, then compares each result with the oldest prediction. Phases
// vary k (including out-of-range values), sender idling and receiver
// stalls, with one long receiver hold-off and one mid-phase drain.
// ----------------------------------------------------------------------------
module tb_top_k_min_sorted_list_unit;
  import tkm_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  localparam logic [2:0] ADDR_K_IN_USE = {REG_K_IN_USE, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam logic [KEY_W-1:0] KEY_NONE = '1;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 66;
  localparam int unsigned HOLD_CYCLES = 200;

  class kth_tracker;
    logic [KEY_W-1:0] keys [LIST_DEPTH];
    logic [ID_W-1:0]  ids [LIST_DEPTH];
    int unsigned      held;
    logic [K_W-1:0]   k_reg;
    tkm_out_t         kth_expected [$];
    int               errors;

    function new();
      held = 0;
      k_reg = K_RESET;
      errors = 0;
    endfunction

    function void set_k(logic [K_W-1:0] k);
      k_reg = k;
    endfunction

    function int unsigned pending();
      return kth_expected.size();
    endfunction

    function void note_pair(tkm_in_t p);
      int unsigned k_eff;
      int unsigned pos;
      int unsigned last;
      int unsigned i;
      tkm_out_t    want;
      k_eff = (k_reg == 0) ? 1 : ((k_reg > LIST_DEPTH) ? LIST_DEPTH : k_reg);
      if (held > k_eff) held = k_eff;
      pos = 0;
      while (pos < held && keys[pos] <= p.item_key) pos++;
      if (pos < k_eff) begin
        last = (held < k_eff) ? held : k_eff - 1;
        for (i = last; i > pos; i--) begin
          keys[i] = keys[i-1];
          ids[i] = ids[i-1];
        end
        keys[pos] = p.item_key;
        ids[pos] = p.item_id;
        if (held < k_eff) held++;
      end
      if (held == k_eff) begin
        want.kth_key = keys[k_eff-1];
        want.list_full = 1'b1;
      end else begin
        want.kth_key = KEY_NONE;
        want.list_full = 1'b0;
      end
      kth_expected.push_back(want);
    endfunction

    function void check_result(tkm_out_t got);
      tkm_out_t want;
      if (kth_expected.size() == 0) begin
        $error("result with no transfer pending: kth_key %h list_full %b",
               got.kth_key, got.list_full);
        errors++;
        return;
      end
      want = kth_expected.pop_front();
      if (got.kth_key !== want.kth_key) begin
        $error("kth_key mismatch: expected %h, actual %h", want.kth_key, got.kth_key);
        errors++;
      end
      if (got.list_full !== want.list_full) begin
        $error("list_full mismatch: expected %b, actual %b", want.list_full, got.list_full);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tkm_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tkm_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  kth_tracker  sb;

  top_k_min_sorted_list_unit #(
    .MAX_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_req) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_pair(in_data);
    end
  end

  task automatic send_item(input logic [KEY_W-1:0] key, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{item_key: key, item_id: id};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_K_IN_USE) sb.set_k(data[K_W-1:0]);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(40);
      4:          return $urandom_range(1) ? KEY_NONE : '0;
      5:          return KEY_NONE - $urandom_range(40);
      default:    return $urandom();
    endcase
  endfunction

  initial begin
    logic [K_W-1:0] k_plan [PHASES];
    int unsigned    ph;
    int unsigned    n;
    k_plan = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2};
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill at reset k, with extremes and ties
    send_item(KEY_NONE, '0);
    send_item('0, '1);
    send_item(32'd5, 31'd1);
    send_item(32'd5, 31'd2);
    send_item(32'd5, 31'd3);
    for (n = 0; n < 11; n++) send_item(32'h8000_0000 + n, ID_W'(31'd10 + n));
    send_item(KEY_NONE, 31'd20);
    send_item(32'd7, 31'd21);
    send_item('0, 31'd22);
    drain();
    // cut below the held count
    write_reg(ADDR_K_IN_USE, 32'd3);
    send_item(32'd6, 31'd23);
    send_item(32'd5, 31'd24);
    drain();
    write_reg(ADDR_K_IN_USE, 32'd0);
    send_item(32'd1, 31'd25);
    send_item('0, 31'd26);
    drain();
    write_reg(ADDR_K_IN_USE, 32'd31);
    send_item(32'd3, 31'd27);
    send_item(32'd2, 31'd28);
    drain();
    write_reg(ADDR_SPARE, 32'd2);
    send_item(32'd4, 31'd29);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      write_reg(ADDR_K_IN_USE, {27'd0, k_plan[ph]});
      if (ph == 2) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) drain();
        send_item(pick_key(), ID_W'($urandom()));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
